### design/sfp_pkg.sv
package sfp_pkg;

  // frame delimiters and type bytes
  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChM      = 8'h4D;  // 'M'
  localparam logic [7:0] ChX      = 8'h58;  // 'X'
  localparam logic [7:0] ChQuery  = 8'h3F;  // '?'
  localparam logic [7:0] ChLt     = 8'h3C;  // '<'
  localparam logic [7:0] ChGt     = 8'h3E;  // '>'

  localparam logic [7:0] CrcPoly = 8'hD5;

  // v2 header is five bytes, counted 0 to 4
  localparam logic [15:0] HdrV2Last = 16'd4;

  // frame kind codes
  localparam logic [2:0] KindNone  = 3'd0;
  localparam logic [2:0] KindV1Cmd = 3'd1;
  localparam logic [2:0] KindV1Rsp = 3'd2;
  localparam logic [2:0] KindV1Ext = 3'd3;
  localparam logic [2:0] KindV2Cmd = 3'd4;
  localparam logic [2:0] KindV2Rsp = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_HDR_M  = 4'd2,
    PH_FLAGS  = 4'd3,
    PH_SIZE   = 4'd4,
    PH_FUNC   = 4'd5,
    PH_PAY_V1 = 4'd6,
    PH_HDR_X  = 4'd7,
    PH_HDR_V2 = 4'd8,
    PH_PAY_V2 = 4'd9,
    PH_CHK_V1 = 4'd10,
    PH_CHK_V2 = 4'd11
  } phase_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_ok;
    logic        frame_bad;
    logic [2:0]  frame_kind;
    logic [7:0]  frame_flags;
    logic [15:0] frame_function;
    logic [15:0] frame_length;
  } result_t;

  // one byte through the crc-8, msb first, initial value zero
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CrcPoly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

### design/sfp_in_reg.sv
module sfp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

### design/sfp_parser.sv
module sfp_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      in_byte,
  output sfp_pkg::result_t result
);

  sfp_pkg::phase_t phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  running_check, running_check_next;
  logic [2:0]  kind_reg, kind_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [15:0] function_reg, function_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] count_inc;
  logic [7:0]  crc_new;
  logic        report;

  assign count_inc = byte_count + 16'd1;
  assign crc_new   = sfp_pkg::crc8_step(running_check, in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfp_pkg::PH_IDLE;
      byte_count    <= '0;
      running_check <= '0;
      kind_reg      <= sfp_pkg::KindNone;
      flags_reg     <= '0;
      function_reg  <= '0;
      length_reg    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      running_check <= running_check_next;
      kind_reg      <= kind_reg_next;
      flags_reg     <= flags_reg_next;
      function_reg  <= function_reg_next;
      length_reg    <= length_reg_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    running_check_next = running_check;
    kind_reg_next      = kind_reg;
    flags_reg_next     = flags_reg;
    function_reg_next  = function_reg;
    length_reg_next    = length_reg;
    report             = 1'b0;
    result             = '0;

    case (phase)
      sfp_pkg::PH_IDLE: begin
        if (in_byte == sfp_pkg::ChDollar) phase_next = sfp_pkg::PH_START;
      end
      sfp_pkg::PH_START: begin
        if (in_byte == sfp_pkg::ChX) begin
          phase_next = sfp_pkg::PH_HDR_X;
        end else if (in_byte == sfp_pkg::ChM) begin
          phase_next = sfp_pkg::PH_HDR_M;
        end else begin
          phase_next         = sfp_pkg::PH_IDLE;
          byte_count_next    = '0;
          running_check_next = '0;
          kind_reg_next      = sfp_pkg::KindNone;
          flags_reg_next     = '0;
          function_reg_next  = '0;
          length_reg_next    = '0;
          result.frame_bad   = 1'b1;
          report             = 1'b1;
        end
      end
      sfp_pkg::PH_HDR_M, sfp_pkg::PH_HDR_X: begin
        byte_count_next    = '0;
        running_check_next = '0;
        kind_reg_next      = sfp_pkg::KindNone;
        flags_reg_next     = '0;
        function_reg_next  = '0;
        length_reg_next    = '0;
        if (phase == sfp_pkg::PH_HDR_M && in_byte == sfp_pkg::ChQuery) begin
          kind_reg_next = sfp_pkg::KindV1Ext;
          phase_next    = sfp_pkg::PH_FLAGS;
        end else if (in_byte == sfp_pkg::ChLt) begin
          kind_reg_next = (phase == sfp_pkg::PH_HDR_M) ? sfp_pkg::KindV1Cmd
                                                       : sfp_pkg::KindV2Cmd;
          phase_next    = (phase == sfp_pkg::PH_HDR_M) ? sfp_pkg::PH_SIZE
                                                       : sfp_pkg::PH_HDR_V2;
        end else if (in_byte == sfp_pkg::ChGt) begin
          kind_reg_next = (phase == sfp_pkg::PH_HDR_M) ? sfp_pkg::KindV1Rsp
                                                       : sfp_pkg::KindV2Rsp;
          phase_next    = (phase == sfp_pkg::PH_HDR_M) ? sfp_pkg::PH_SIZE
                                                       : sfp_pkg::PH_HDR_V2;
        end else begin
          phase_next       = sfp_pkg::PH_IDLE;
          result.frame_bad = 1'b1;
          report           = 1'b1;
        end
      end
      sfp_pkg::PH_FLAGS: begin
        flags_reg_next = in_byte;
        phase_next     = sfp_pkg::PH_SIZE;
      end
      sfp_pkg::PH_SIZE: begin
        length_reg_next    = {8'd0, in_byte};
        running_check_next = running_check ^ in_byte;
        phase_next         = sfp_pkg::PH_FUNC;
      end
      sfp_pkg::PH_FUNC: begin
        function_reg_next  = {8'd0, in_byte};
        running_check_next = running_check ^ in_byte;
        phase_next = (length_reg == '0) ? sfp_pkg::PH_CHK_V1 : sfp_pkg::PH_PAY_V1;
      end
      sfp_pkg::PH_PAY_V1, sfp_pkg::PH_PAY_V2: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = in_byte;
        result.payload_index = byte_count;
        running_check_next   = (phase == sfp_pkg::PH_PAY_V1) ? (running_check ^ in_byte)
                                                             : crc_new;
        byte_count_next      = count_inc;
        if (count_inc == length_reg) begin
          phase_next = (phase == sfp_pkg::PH_PAY_V1) ? sfp_pkg::PH_CHK_V1
                                                     : sfp_pkg::PH_CHK_V2;
        end
      end
      sfp_pkg::PH_HDR_V2: begin
        running_check_next = crc_new;
        case (byte_count[2:0])
          3'd0:    flags_reg_next    = in_byte;
          3'd1:    function_reg_next = {function_reg[15:8], in_byte};
          3'd2:    function_reg_next = {in_byte, function_reg[7:0]};
          3'd3:    length_reg_next   = {length_reg[15:8], in_byte};
          default: length_reg_next   = {in_byte, length_reg[7:0]};
        endcase
        byte_count_next = count_inc;
        if (byte_count >= sfp_pkg::HdrV2Last) begin
          byte_count_next = '0;
          phase_next = (length_reg_next == '0) ? sfp_pkg::PH_CHK_V2 : sfp_pkg::PH_PAY_V2;
        end
      end
      sfp_pkg::PH_CHK_V1, sfp_pkg::PH_CHK_V2: begin
        result.frame_ok  = (running_check == in_byte);
        result.frame_bad = (running_check != in_byte);
        report           = 1'b1;
        phase_next       = sfp_pkg::PH_IDLE;
      end
      default: begin
        phase_next = sfp_pkg::PH_IDLE;
      end
    endcase

    if (report) begin
      result.frame_kind     = kind_reg_next;
      result.frame_flags    = flags_reg_next;
      result.frame_function = function_reg_next;
      result.frame_length   = length_reg_next;
    end
  end

endmodule

### design/sfp_out_reg.sv
module sfp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfp_pkg::result_t result,
  output logic             out_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [63:0]      m_tdata,
  output logic [5:0]       m_tuser
);

  sfp_pkg::result_t held;

  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {held.frame_length, held.frame_function, held.frame_flags,
                    held.payload_index, held.payload_byte};
  assign m_tuser = {held.frame_kind, held.frame_bad, held.frame_ok, held.payload_valid};

endmodule

### design/serial_frame_parser_v1_v2.sv
// deframer for the v1 and v2 forms of the '$'-delimited serial command protocol.
// one received byte goes in per word on the slave side and exactly one result word
// comes out per byte on the master side. payload bytes are flagged with their index
// within the payload as they arrive; on the checksum byte the result carries frame
// ok or frame bad plus the header fields (kind, flags, function, length), which read
// zero on every other word. a malformed byte after '$' or an unknown type byte also
// gives frame bad with zero header fields. v1 frames use an xor checksum over size,
// function and payload (the extended '?' flags byte is not covered); v2 frames use
// crc-8, polynomial 0xd5, over the five-byte header and the payload. the parser is
// idle again straight after the checksum byte. throughput is one byte per clock:
// the byte sits in an input register, the parse step and the crc-8 over all eight
// bits are combinational, and the result lands in an output register; a new byte is
// taken every cycle while the master side keeps taking words.
module serial_frame_parser_v1_v2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_flags,
  // [47:32] frame_function, [63:48] frame_length
  output logic [63:0] m_tdata,
  // [0] payload_valid, [1] frame_ok, [2] frame_bad, [5:3] frame_kind
  output logic [5:0]  m_tuser
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_ready;
  logic             advance;
  sfp_pkg::result_t result;

  // a byte moves from the input register into the parser whenever the
  // output register is empty or being drained this cycle
  assign advance = in_valid && out_ready;

  sfp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  // frame state machine, running checksum and header capture
  sfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .result  (result)
  );

  sfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

### design/sfp_checker.sv
module sfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [5:0]  m_tuser
);

  // payload, frame ok and frame bad are mutually exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser[2:0]))
    else $error("payload, frame ok and frame bad overlap");

  // header fields stay zero unless the word reports a frame
  a_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1] && !m_tuser[2]) |-> (m_tdata[63:24] == 40'd0 &&
                                                  m_tuser[5:3] == 3'd0))
    else $error("header fields set without a frame report");

  // payload words taken on consecutive edges count up by one
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[0] && $past(m_tvalid && m_tready && m_tuser[0], 1))
      |-> (m_tdata[23:8] == $past(m_tdata[23:8], 1) + 16'd1))
    else $error("payload index out of sequence");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result word changed while stalled");

  // with the output side empty an offered byte is always taken
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !m_tvalid) |-> s_tready)
    else $error("input stalled with an empty output");

endmodule

bind serial_frame_parser_v1_v2 sfp_checker u_sfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
